FILE: hw/rtl/json_string_unescape_utf8_top_macros.svh
// assertion macros for the json string decoder
// no dependencies; included by the top level
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define JSU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define JSU_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define JSU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define JSU_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: hw/rtl/jsu_pkg.sv
// shared types, character codes and helper functions of the json string decoder
// no dependencies
package jsu_pkg;

   localparam int CP_W    = 21;
   localparam int BYTES_W = 32;
   localparam int COUNT_W = 3;
   localparam int ERR_W   = 4;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // register index is paddr[2]
   localparam logic REG_CTRL = 1'b0;

   localparam logic [CP_W-1:0] CH_QUOTE  = 21'h22;
   localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
   localparam logic [CP_W-1:0] CH_SLASH  = 21'h2F;
   localparam logic [CP_W-1:0] CH_APOS   = 21'h27;
   localparam logic [CP_W-1:0] CH_ZERO   = 21'h30;
   localparam logic [CP_W-1:0] CH_B      = 21'h62;
   localparam logic [CP_W-1:0] CH_F      = 21'h66;
   localparam logic [CP_W-1:0] CH_N      = 21'h6E;
   localparam logic [CP_W-1:0] CH_R      = 21'h72;
   localparam logic [CP_W-1:0] CH_T      = 21'h74;
   localparam logic [CP_W-1:0] CH_U      = 21'h75;
   localparam logic [CP_W-1:0] CH_SPACE  = 21'h20;
   localparam logic [CP_W-1:0] CH_BS_CTL = 21'h08;
   localparam logic [CP_W-1:0] CH_FF_CTL = 21'h0C;
   localparam logic [CP_W-1:0] CH_LF_CTL = 21'h0A;
   localparam logic [CP_W-1:0] CH_CR_CTL = 21'h0D;
   localparam logic [CP_W-1:0] CH_HT_CTL = 21'h09;
   localparam logic [CP_W-1:0] CH_NUL    = 21'h00;
   localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

   // top six bits of a high and a low surrogate
   localparam logic [5:0] SURR_HI_TAG = 6'b110110;
   localparam logic [5:0] SURR_LO_TAG = 6'b110111;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_STR     = 4'd1,
      PH_ESC     = 4'd2,
      PH_HEX_HI  = 4'd3,
      PH_WANT_BS = 4'd4,
      PH_WANT_U  = 4'd5,
      PH_HEX_LO  = 4'd6
   } jsu_phase_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 4'd0,
      ERR_NO_QUOTE   = 4'd1,
      ERR_BAD_ESC    = 4'd2,
      ERR_NONSTD     = 4'd3,
      ERR_BAD_HEX    = 4'd4,
      ERR_MISS_LOW   = 4'd5,
      ERR_BAD_LOW    = 4'd6,
      ERR_STRAY_LOW  = 4'd7,
      ERR_CTRL_CHAR  = 4'd8,
      ERR_UNTERM     = 4'd9
   } jsu_err_type;

   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [COUNT_W-1:0] count;
   } jsu_utf8_type;

   // {valid, nibble}
   function automatic logic [4:0] hex_of(input logic [CP_W-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 21'h30 && c <= 21'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic jsu_utf8_type utf8_enc(input logic [CP_W-1:0] cp);
      jsu_utf8_type r;
      if (cp < 21'h80) begin
         r.bytes = {25'd0, cp[6:0]};
         r.count = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
         r.count = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
         r.count = 3'd3;
      end else begin
         r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
         r.count = 3'd4;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/jsu_req_if.sv
// input channel of the json string decoder: one code point per word
// depends on jsu_pkg
interface jsu_req_if;
   logic                       valid;
   logic                       ready;
   logic [jsu_pkg::CP_W-1:0]   code_point;
   logic                       end_of_input;

   modport source (output valid, output code_point, output end_of_input, input ready);
   modport sink   (input valid, input code_point, input end_of_input, output ready);
endinterface

FILE: hw/rtl/jsu_rsp_if.sv
// result channel of the json string decoder: at most one decoded character per word
// depends on jsu_pkg
interface jsu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [jsu_pkg::BYTES_W-1:0]   utf8_bytes;
   logic [jsu_pkg::COUNT_W-1:0]   byte_count;
   logic                          string_done;
   logic [jsu_pkg::ERR_W-1:0]     error_code;

   modport source (output valid, output utf8_bytes, output byte_count, output string_done,
                   output error_code, input ready);
   modport sink   (input valid, input utf8_bytes, input byte_count, input string_done,
                   input error_code, output ready);
endinterface

FILE: hw/rtl/json_string_unescape_utf8_top.sv
// top level of the json string decoder: control register and decode pipeline
// depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_csr, jsu_core and the macros header
//
//   port      role     word
//   req_ch    sink     code_point, end_of_input
//   rsp_ch    source   utf8_bytes, byte_count, string_done, error_code
//   csr_*     apb      nonstd escape enable bit at byte address 0
//
// one word in and one word out per cycle while rsp_ch is not stalled; an accepted word passes through the input
// register and then the result register before rsp_ch.valid rises, and the rate is set by the single decode step
// between the input and result registers; synchronous active-high reset puts the decoder in idle, waiting for the
// opening quote; a stalled rsp_ch holds the result register, the input register still takes one word
`include "json_string_unescape_utf8_top_macros.svh"

module json_string_unescape_utf8_top (
   input  logic                        clock,
   input  logic                        reset,
   jsu_req_if.sink                     req_ch,
   jsu_rsp_if.source                   rsp_ch,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [jsu_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [jsu_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [jsu_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import jsu_pkg::*;

   logic allow_nonstd;

   jsu_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .allow_nonstd (allow_nonstd)
   );

   jsu_core u_core (
      .clock        (clock),
      .reset        (reset),
      .allow_nonstd (allow_nonstd),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch)
   );

   `JSU_ASSERT_IMPLY(a_done_clean, clock, reset, rsp_ch.valid && rsp_ch.string_done, rsp_ch.byte_count == 3'd0 && rsp_ch.error_code == ERR_NONE, "closing quote word carries bytes or an error")
   `JSU_ASSERT_IMPLY(a_err_empty, clock, reset, rsp_ch.valid && rsp_ch.error_code != ERR_NONE, rsp_ch.byte_count == 3'd0 && !rsp_ch.string_done, "error word carries bytes or done")
   `JSU_ASSERT_IMPLY(a_one_byte, clock, reset, rsp_ch.valid && rsp_ch.byte_count == 3'd1, rsp_ch.utf8_bytes[31:8] == 24'd0, "bytes beyond the count are not zero")
   `JSU_ASSERT_IMPLY(a_no_bubble, clock, reset, !rsp_ch.valid, req_ch.ready, "input stalled while the result register is empty")
   `JSU_ASSERT_NEVER(a_count_range, clock, reset, rsp_ch.valid && rsp_ch.byte_count > 3'd4, "byte count above four")
endmodule

FILE: hw/rtl/jsu_csr.sv
// apb control register of the json string decoder
// depends on jsu_pkg
module jsu_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [jsu_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [jsu_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [jsu_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output logic                        allow_nonstd
);
   import jsu_pkg::*;

   logic allow_ff;
   logic allow_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      allow_in = allow_ff;
      if (wr_en && csr_paddr[2] == REG_CTRL) begin
         allow_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
      end else begin
         allow_ff <= allow_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_CTRL: csr_prdata = {{(DATA_W-1){1'b0}}, allow_ff};
         default:  csr_prdata = '0;
      endcase
   end

   assign allow_nonstd = allow_ff;
endmodule

FILE: hw/rtl/jsu_core.sv
// input register, string/escape state machine with utf-8 encoder, result register
// depends on jsu_pkg, jsu_req_if, jsu_rsp_if
module jsu_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       allow_nonstd,
   jsu_req_if.sink    req_ch,
   jsu_rsp_if.source  rsp_ch
);
   import jsu_pkg::*;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [CP_W-1:0]   in_cp_ff;
   logic              in_eoi_ff;

   // decoder state
   jsu_phase_type     phase_ff, phase_in;
   logic [15:0]       hex_ff, hex_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [9:0]        high_ff, high_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   logic [BYTES_W-1:0] out_bytes_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic              out_done_ff;
   logic [ERR_W-1:0]  out_err_ff;

   logic              advance;
   logic              at_end;
   logic [CP_W-1:0]   c;
   logic [4:0]        hex_d;
   logic [15:0]       hex_next;
   logic              enc_en;
   logic [CP_W-1:0]   enc_cp;
   jsu_utf8_type      enc;
   logic              fail;
   jsu_err_type       err;
   logic              done;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   assign c        = in_cp_ff;
   assign at_end   = in_eoi_ff || (in_cp_ff == CH_NUL);
   assign hex_d    = hex_of(in_cp_ff);
   assign hex_next = {hex_ff[11:0], hex_d[3:0]};

   always_comb begin
      phase_in = phase_ff;
      hex_in   = hex_ff;
      cnt_in   = cnt_ff;
      high_in  = high_ff;
      enc_en   = 1'b0;
      enc_cp   = c;
      fail     = 1'b0;
      err      = ERR_NONE;
      done     = 1'b0;
      unique case (phase_ff)
         PH_STR: begin
            if (at_end) begin
               fail = 1'b1;
               err  = ERR_UNTERM;
            end else if (c == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else if (c == CH_QUOTE) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else if (c < CH_SPACE) begin
               fail = 1'b1;
               err  = ERR_CTRL_CHAR;
            end else begin
               enc_en = 1'b1;
            end
         end
         PH_ESC: begin
            if (at_end) begin
               fail = 1'b1;
               err  = ERR_BAD_ESC;
            end else begin
               phase_in = PH_STR;
               unique case (c) inside
                  CH_QUOTE, CH_BSLASH, CH_SLASH: enc_en = 1'b1;
                  CH_B: begin
                     enc_en = 1'b1;
                     enc_cp = CH_BS_CTL;
                  end
                  CH_F: begin
                     enc_en = 1'b1;
                     enc_cp = CH_FF_CTL;
                  end
                  CH_N: begin
                     enc_en = 1'b1;
                     enc_cp = CH_LF_CTL;
                  end
                  CH_R: begin
                     enc_en = 1'b1;
                     enc_cp = CH_CR_CTL;
                  end
                  CH_T: begin
                     enc_en = 1'b1;
                     enc_cp = CH_HT_CTL;
                  end
                  CH_ZERO, CH_APOS: begin
                     if (!allow_nonstd) begin
                        fail = 1'b1;
                        err  = ERR_NONSTD;
                     end else begin
                        enc_en = 1'b1;
                        enc_cp = (c == CH_ZERO) ? CH_NUL : CH_APOS;
                     end
                  end
                  CH_U: begin
                     phase_in = PH_HEX_HI;
                     hex_in   = 16'd0;
                     cnt_in   = 2'd0;
                  end
                  default: begin
                     fail = 1'b1;
                     err  = ERR_BAD_ESC;
                  end
               endcase
            end
         end
         PH_HEX_HI, PH_HEX_LO: begin
            if (at_end || !hex_d[4]) begin
               fail = 1'b1;
               err  = ERR_BAD_HEX;
            end else if (cnt_ff != 2'd3) begin
               hex_in = hex_next;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               hex_in = 16'd0;
               cnt_in = 2'd0;
               if (phase_ff == PH_HEX_HI) begin
                  if (hex_next[15:10] == SURR_HI_TAG) begin
                     high_in  = hex_next[9:0];
                     phase_in = PH_WANT_BS;
                  end else if (hex_next[15:10] == SURR_LO_TAG) begin
                     fail = 1'b1;
                     err  = ERR_STRAY_LOW;
                  end else begin
                     enc_en   = 1'b1;
                     enc_cp   = {5'd0, hex_next};
                     phase_in = PH_STR;
                  end
               end else begin
                  if (hex_next[15:10] != SURR_LO_TAG) begin
                     fail = 1'b1;
                     err  = ERR_BAD_LOW;
                  end else begin
                     enc_en   = 1'b1;
                     enc_cp   = SUPP_BASE + {1'b0, high_ff, hex_next[9:0]};
                     phase_in = PH_STR;
                  end
               end
            end
         end
         PH_WANT_BS: begin
            if (at_end || c != CH_BSLASH) begin
               fail = 1'b1;
               err  = ERR_MISS_LOW;
            end else begin
               phase_in = PH_WANT_U;
            end
         end
         PH_WANT_U: begin
            if (at_end || c != CH_U) begin
               fail = 1'b1;
               err  = ERR_MISS_LOW;
            end else begin
               phase_in = PH_HEX_LO;
               hex_in   = 16'd0;
               cnt_in   = 2'd0;
            end
         end
         default: begin
            // idle, and any unassigned phase code
            if (!at_end && c == CH_QUOTE) begin
               phase_in = PH_STR;
            end else begin
               fail = 1'b1;
               err  = ERR_NO_QUOTE;
            end
         end
      endcase
      if (fail) begin
         phase_in = PH_IDLE;
         hex_in   = 16'd0;
         cnt_in   = 2'd0;
      end
   end

   assign enc = utf8_enc(enc_cp);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         hex_ff       <= 16'd0;
         cnt_ff       <= 2'd0;
         high_ff      <= 10'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_valid_ff) begin
            phase_ff <= phase_in;
            hex_ff   <= hex_in;
            cnt_ff   <= cnt_in;
            high_ff  <= high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_cp_ff  <= req_ch.code_point;
         in_eoi_ff <= req_ch.end_of_input;
      end
      if (advance) begin
         out_bytes_ff <= enc_en ? enc.bytes : '0;
         out_count_ff <= enc_en ? enc.count : '0;
         out_done_ff  <= done;
         out_err_ff   <= err;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.utf8_bytes  = out_bytes_ff;
   assign rsp_ch.byte_count  = out_count_ff;
   assign rsp_ch.string_done = out_done_ff;
   assign rsp_ch.error_code  = out_err_ff;
endmodule
